[rtl/aft_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aft_pkg
// Shared types and constants of the ADIF field tokenizer.
// ----------------------------------------------------------------------------
package aft_pkg;

  localparam int NAME_MAX  = 32;
  localparam int NAME_AW   = $clog2(NAME_MAX);
  localparam int NAME_CW   = $clog2(NAME_MAX + 1);
  localparam int LEN_W     = 11;
  localparam int ACC_W     = LEN_W + 4;
  localparam int QDEPTH    = 4;
  localparam int QAW       = $clog2(QDEPTH);
  localparam int QCW       = $clog2(QDEPTH + 1);

  localparam logic [LEN_W-1:0] LIMIT_RESET = LEN_W'(1024);
  localparam logic [ACC_W-1:0] LEN_CEIL    = ACC_W'(2047);

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_R     = 8'h52;

  typedef enum logic [2:0] {
    EV_NAME  = 3'd0,
    EV_VALUE = 3'd1,
    EV_FEND  = 3'd2,
    EV_HEND  = 3'd3,
    EV_REND  = 3'd4
  } ev_kind_e;

  typedef enum logic [1:0] {
    CLS_SKIP  = 2'd0,
    CLS_FIELD = 2'd1,
    CLS_EOH   = 2'd2,
    CLS_EOR   = 2'd3
  } cls_e;

  typedef enum logic [2:0] {
    ST_OUT,
    ST_TAG,
    ST_NRD,
    ST_NPUSH,
    ST_VAL,
    ST_END
  } fe_state_e;

  typedef struct packed {
    ev_kind_e   kind;
    logic [7:0] data;
    logic       last;
  } event_t;

endpackage

[rtl/aft_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aft_front
// Tag parser: takes stream bytes, stores tag names, classifies fields and
// pushes events into the event queue.
// ----------------------------------------------------------------------------
module aft_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [10:0]     cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [7:0]      in_byte_i,
  output logic            push_o,
  output aft_pkg::event_t push_ev_o,
  input  logic            q_ready_i
);
  import aft_pkg::*;

  fe_state_e          state_q, state_d;
  logic [NAME_CW-1:0] cnt_q, cnt_d;
  logic [NAME_CW-1:0] colon_q, colon_d;
  logic               colon_seen_q, colon_seen_d;
  logic               dig_done_q, dig_done_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic               over_q, over_d;
  cls_e               cls_q, cls_d;
  logic               hdr_q, hdr_d;
  logic [NAME_CW-1:0] nlen_q, nlen_d;
  logic [NAME_CW-1:0] idx_q, idx_d;
  logic [LEN_W-1:0]   limit_q;
  logic [7:0]         head_q [3];
  logic [7:0]         mem [NAME_MAX];
  logic [7:0]         rd_data_q;

  logic               acc_in;
  logic               store_en;
  logic [NAME_CW-1:0] namelen;
  logic [LEN_W-1:0]   tag_len;
  logic               is_eoh;
  logic               is_eor;
  cls_e               tag_cls;
  logic [ACC_W-1:0]   acc;
  logic [LEN_W-1:0]   left_n;
  logic               is_digit;

  assign in_ready_o = (state_q == ST_OUT) || (state_q == ST_TAG)
                      || ((state_q == ST_VAL) && q_ready_i);
  assign acc_in   = in_valid_i && in_ready_o;
  assign store_en = acc_in && (state_q == ST_TAG) && (in_byte_i != CH_GT)
                    && (cnt_q < NAME_CW'(NAME_MAX));
  assign namelen  = colon_seen_q ? colon_q : cnt_q;
  assign tag_len  = (colon_seen_q && !over_q && (len_q <= limit_q)) ? len_q : '0;
  assign is_eoh   = (namelen == NAME_CW'(3)) && (head_q[0] == CH_E)
                    && (head_q[1] == CH_O) && (head_q[2] == CH_H);
  assign is_eor   = (namelen == NAME_CW'(3)) && (head_q[0] == CH_E)
                    && (head_q[1] == CH_O) && (head_q[2] == CH_R);
  assign is_digit = (in_byte_i >= CH_0) && (in_byte_i <= CH_9);
  assign acc      = ({4'b0, len_q} << 3) + ({4'b0, len_q} << 1)
                    + ACC_W'(in_byte_i - CH_0);
  assign left_n   = len_q - LEN_W'(1);

  always_comb begin
    if (is_eoh) begin
      tag_cls = CLS_EOH;
    end else if (hdr_q && is_eor) begin
      tag_cls = CLS_EOR;
    end else if (hdr_q) begin
      tag_cls = CLS_FIELD;
    end else begin
      tag_cls = CLS_SKIP;
    end
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    colon_d      = colon_q;
    colon_seen_d = colon_seen_q;
    dig_done_d   = dig_done_q;
    len_d        = len_q;
    over_d       = over_q;
    cls_d        = cls_q;
    hdr_d        = hdr_q;
    nlen_d       = nlen_q;
    idx_d        = idx_q;
    push_o       = 1'b0;
    push_ev_o    = '{kind: EV_NAME, data: '0, last: 1'b0};
    case (state_q)
      ST_OUT: begin
        if (acc_in && in_byte_i == CH_LT) begin
          cnt_d        = '0;
          colon_d      = '0;
          colon_seen_d = 1'b0;
          dig_done_d   = 1'b0;
          len_d        = '0;
          over_d       = 1'b0;
          state_d      = ST_TAG;
        end
      end
      ST_TAG: begin
        if (acc_in) begin
          if (in_byte_i == CH_GT) begin
            nlen_d = namelen;
            len_d  = tag_len;
            cls_d  = tag_cls;
            idx_d  = '0;
            if (tag_cls == CLS_FIELD && namelen != '0) begin
              state_d = ST_NRD;
            end else if (tag_len != '0) begin
              state_d = ST_VAL;
            end else if (tag_cls != CLS_SKIP) begin
              state_d = ST_END;
            end else begin
              state_d = ST_OUT;
            end
          end else begin
            if (in_byte_i == CH_COLON) begin
              colon_seen_d = 1'b1;
              colon_d      = cnt_q;
              dig_done_d   = 1'b0;
              len_d        = '0;
              over_d       = 1'b0;
            end else if (colon_seen_q && !dig_done_q) begin
              if (is_digit) begin
                if (!over_q) begin
                  if (acc > LEN_CEIL) begin
                    over_d = 1'b1;
                  end else begin
                    len_d = acc[LEN_W-1:0];
                  end
                end
              end else begin
                dig_done_d = 1'b1;
              end
            end
            if (cnt_q < NAME_CW'(NAME_MAX)) begin
              cnt_d = cnt_q + NAME_CW'(1);
            end
          end
        end
      end
      ST_NRD: begin
        state_d = ST_NPUSH;
      end
      ST_NPUSH: begin
        if (q_ready_i) begin
          push_o    = 1'b1;
          push_ev_o = '{kind: EV_NAME, data: rd_data_q, last: 1'b0};
          if (idx_q == nlen_q - NAME_CW'(1)) begin
            push_ev_o.last = (len_q != '0);
            state_d        = (len_q != '0) ? ST_VAL : ST_END;
          end else begin
            idx_d   = idx_q + NAME_CW'(1);
            state_d = ST_NRD;
          end
        end
      end
      ST_VAL: begin
        if (acc_in) begin
          len_d = left_n;
          if (cls_q == CLS_FIELD) begin
            push_o    = 1'b1;
            push_ev_o = '{kind: EV_VALUE, data: in_byte_i, last: (left_n != '0)};
          end
          if (left_n == '0) begin
            state_d = (cls_q == CLS_SKIP) ? ST_OUT : ST_END;
          end
        end
      end
      ST_END: begin
        if (q_ready_i) begin
          push_o  = 1'b1;
          state_d = ST_OUT;
          case (cls_q)
            CLS_FIELD: push_ev_o = '{kind: EV_FEND, data: '0, last: 1'b1};
            CLS_EOH: begin
              push_ev_o = '{kind: EV_HEND, data: '0, last: 1'b1};
              hdr_d     = 1'b1;
            end
            CLS_EOR:   push_ev_o = '{kind: EV_REND, data: '0, last: 1'b1};
            default:   push_o = 1'b0;
          endcase
        end
      end
      default: begin
        state_d = ST_OUT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_OUT;
      cnt_q        <= '0;
      colon_q      <= '0;
      colon_seen_q <= 1'b0;
      dig_done_q   <= 1'b0;
      len_q        <= '0;
      over_q       <= 1'b0;
      cls_q        <= CLS_SKIP;
      hdr_q        <= 1'b0;
      nlen_q       <= '0;
      idx_q        <= '0;
      limit_q      <= LIMIT_RESET;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      colon_q      <= colon_d;
      colon_seen_q <= colon_seen_d;
      dig_done_q   <= dig_done_d;
      len_q        <= len_d;
      over_q       <= over_d;
      cls_q        <= cls_d;
      hdr_q        <= hdr_d;
      nlen_q       <= nlen_d;
      idx_q        <= idx_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_en) begin
      mem[cnt_q[NAME_AW-1:0]] <= in_byte_i;
      if (cnt_q < NAME_CW'(3)) begin
        head_q[cnt_q[1:0]] <= in_byte_i;
      end
    end
    rd_data_q <= mem[idx_q[NAME_AW-1:0]];
  end

  a_nrd_to_npush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_NRD |=> state_q == ST_NPUSH)
    else $error("name read not followed by name push");

  a_hdr_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hdr_q |=> hdr_q)
    else $error("header flag cleared");

  a_push_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> q_ready_i)
    else $error("event pushed into full queue");

  a_no_take_in_name: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_NRD || state_q == ST_NPUSH || state_q == ST_END) |-> !in_ready_o)
    else $error("byte taken while emitting");

endmodule

[rtl/aft_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aft_queue
// Short event queue between the tag parser and the output stage.
// ----------------------------------------------------------------------------
module aft_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  aft_pkg::event_t push_ev_i,
  output logic            ready_o,
  input  logic            pop_i,
  output logic            avail_o,
  output aft_pkg::event_t pop_ev_o
);
  import aft_pkg::*;

  event_t         slot_q [QDEPTH];
  logic [QAW-1:0] wr_q, rd_q;
  logic [QCW-1:0] cnt_q;
  logic           do_push, do_pop;

  assign ready_o  = (cnt_q != QCW'(QDEPTH));
  assign avail_o  = (cnt_q != '0);
  assign pop_ev_o = slot_q[rd_q];
  assign do_push  = push_i && ready_o;
  assign do_pop   = pop_i && avail_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + QAW'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + QAW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + QCW'(1);
        2'b01:   cnt_q <= cnt_q - QCW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= push_ev_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCW'(QDEPTH))
    else $error("queue count out of range");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_q - rd_q == cnt_q[QAW-1:0])
    else $error("queue pointers disagree with count");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && ready_o && !(pop_i && avail_o)) |=> cnt_q == $past(cnt_q) + QCW'(1))
    else $error("push lost");

endmodule

[rtl/aft_emit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aft_emit
// Output stage: pops events from the queue into the master-side word
// register and holds them until taken.
// ----------------------------------------------------------------------------
module aft_emit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            avail_i,
  input  aft_pkg::event_t ev_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output aft_pkg::event_t out_ev_o
);
  import aft_pkg::*;

  logic   valid_q;
  event_t ev_q;

  assign pop_o       = avail_i && (!valid_q || out_ready_i);
  assign out_valid_o = valid_q;
  assign out_ev_o    = ev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!valid_q || out_ready_i) begin
      valid_q <= avail_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ev_q <= ev_i;
    end
  end

  a_hold_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !out_ready_i) |=> (valid_q && ev_q == $past(ev_q)))
    else $error("pending word dropped");

  a_pop_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> valid_q)
    else $error("popped event not loaded");

  a_pop_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (!valid_q || out_ready_i))
    else $error("pop over a held word");

endmodule

[rtl/adif_field_tokenizer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adif_field_tokenizer_unit
// ADIF field tokenizer: splits a byte stream into name, value and end events.
// ----------------------------------------------------------------------------
// Bytes outside a tag, inside a tag and inside a value are taken one per
// cycle, value bytes only while the event queue has room. At '>' of a data
// field the unit stops taking bytes and replays the stored name from its tag
// memory, a read state and then a push state per name byte; an end event
// has a state of its own. A four-word event queue and an output register let
// the parser keep taking bytes while the sink stalls. value_length_limit
// (cfg_wdata_i) resets to 1024 and may be written only while the unit is idle.
// ----------------------------------------------------------------------------
module adif_field_tokenizer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_wdata_i,     // value_length_limit
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,    // [7:0] in_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,    // [7:0] event_byte
  output logic [2:0]  m_axis_tuser,    // [2:0] event_kind
  output logic        m_axis_tlast     // last_of_run
);
  import aft_pkg::*;

  logic   push, q_ready, pop, avail;
  event_t push_ev, pop_ev, out_ev;

  aft_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .push_o      (push),
    .push_ev_o   (push_ev),
    .q_ready_i   (q_ready)
  );

  aft_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_ev_i (push_ev),
    .ready_o   (q_ready),
    .pop_i     (pop),
    .avail_o   (avail),
    .pop_ev_o  (pop_ev)
  );

  aft_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .avail_i     (avail),
    .ev_i        (pop_ev),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_ev_o    (out_ev)
  );

  assign m_axis_tdata = out_ev.data;
  assign m_axis_tuser = out_ev.kind;
  assign m_axis_tlast = out_ev.last;

endmodule

[test/adif_field_tokenizer_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adif_field_tokenizer_unit_tb
// Self-checking bench for the ADIF field tokenizer.
// ----------------------------------------------------------------------------
// Streams ADIF text into the unit one byte per word and tracks the tokenizer
// state in the bench to predict every name, value and end event. Directed
// tasks cover skipped header fields, end tags, truncated names and malformed
// lengths at several length limits. Random records with random content and
// some noise follow. Both stream sides idle at random, the sink holds off for
// a long stretch once, and every output word is compared in order.
// ----------------------------------------------------------------------------
module adif_field_tokenizer_unit_tb;
  import aft_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned DRAIN_CYCLES = 100;

  typedef enum logic [1:0] {
    PH_OUT = 2'd0,
    PH_TAG = 2'd1,
    PH_VAL = 2'd2
  } tok_phase_e;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [LEN_W-1:0] cfg_wdata_i;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [7:0]       m_axis_tdata;
  logic [2:0]       m_axis_tuser;
  logic             m_axis_tlast;

  adif_field_tokenizer_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // tokenizer state tracked by the bench
  tok_phase_e       ph          = PH_OUT;
  logic [7:0]       name_mem [NAME_MAX];
  int unsigned      stored_cnt  = 0;
  int unsigned      colon_pos   = 0;
  int unsigned      len_acc     = 0;
  logic             colon_seen  = 1'b0;
  logic             digits_done = 1'b0;
  logic             len_over    = 1'b0;
  logic             hdr_passed  = 1'b0;
  cls_e             cls         = CLS_SKIP;
  logic [LEN_W-1:0] len_limit   = LIMIT_RESET;

  event_t      pending_events[$];
  int unsigned active_bytes = 0;
  int unsigned fail_cnt     = 0;
  int unsigned cycle_cnt    = 0;
  int unsigned sink_hold    = 0;
  bit          src_calm     = 1'b0;
  bit          sink_calm    = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic void emit(ev_kind_e kind, logic [7:0] data);
    event_t ev;
    ev.kind = kind;
    ev.data = data;
    ev.last = 1'b0;
    pending_events = {pending_events, ev};
  endfunction

  function automatic logic is_word(int unsigned len, logic [7:0] c0, logic [7:0] c1,
                                   logic [7:0] c2);
    return len == 3 && name_mem[0] == c0 && name_mem[1] == c1 && name_mem[2] == c2;
  endfunction

  function automatic void close_field();
    case (cls)
      CLS_FIELD: emit(EV_FEND, 8'h00);
      CLS_EOH: begin
        emit(EV_HEND, 8'h00);
        hdr_passed = 1'b1;
      end
      CLS_EOR: emit(EV_REND, 8'h00);
      default: ;
    endcase
    ph = PH_OUT;
  endfunction

  function automatic void tokenize_byte(logic [7:0] b);
    int unsigned n0;
    int unsigned nlen;
    int unsigned vlen;
    int unsigned acc;
    n0 = pending_events.size();
    if (ph != PH_OUT || b == CH_LT) active_bytes++;
    case (ph)
      PH_TAG: begin
        if (b == CH_GT) begin
          nlen = colon_seen ? colon_pos : stored_cnt;
          if (nlen > NAME_MAX) nlen = NAME_MAX;
          vlen = (colon_seen && !len_over && len_acc <= len_limit) ? len_acc : 0;
          if (is_word(nlen, CH_E, CH_O, CH_H)) cls = CLS_EOH;
          else if (hdr_passed && is_word(nlen, CH_E, CH_O, CH_R)) cls = CLS_EOR;
          else if (hdr_passed) cls = CLS_FIELD;
          else cls = CLS_SKIP;
          if (cls == CLS_FIELD) begin
            for (int unsigned i = 0; i < nlen; i++) emit(EV_NAME, name_mem[i]);
          end
          len_acc = vlen;
          if (vlen > 0) ph = PH_VAL;
          else close_field();
        end else begin
          if (b == CH_COLON) begin
            colon_seen  = 1'b1;
            colon_pos   = stored_cnt;
            digits_done = 1'b0;
            len_acc     = 0;
            len_over    = 1'b0;
          end else if (colon_seen && !digits_done) begin
            if (b >= CH_0 && b <= CH_9) begin
              if (!len_over) begin
                acc = len_acc * 10 + int'(b - CH_0);
                if (acc > 2047) len_over = 1'b1;
                else len_acc = acc;
              end
            end else begin
              digits_done = 1'b1;
            end
          end
          if (stored_cnt < NAME_MAX) begin
            name_mem[stored_cnt] = b;
            stored_cnt++;
          end
        end
      end
      PH_VAL: begin
        if (cls == CLS_FIELD) emit(EV_VALUE, b);
        if (len_acc > 0) len_acc--;
        if (len_acc == 0) close_field();
      end
      default: begin
        ph = PH_OUT;
        if (b == CH_LT) begin
          stored_cnt  = 0;
          colon_pos   = 0;
          colon_seen  = 1'b0;
          digits_done = 1'b0;
          len_acc     = 0;
          len_over    = 1'b0;
          ph          = PH_TAG;
        end
      end
    endcase
    if (pending_events.size() > n0) pending_events[pending_events.size() - 1].last = 1'b1;
  endfunction

  task automatic check_event();
    event_t ev;
    if (pending_events.size() == 0) begin
      $error("unexpected word: event_kind %0d event_byte %02h last_of_run %0b",
             m_axis_tuser, m_axis_tdata, m_axis_tlast);
      fail_cnt++;
    end else begin
      ev = pending_events.pop_front();
      if (m_axis_tuser !== ev.kind) begin
        $error("event_kind: expected %0d, got %0d", ev.kind, m_axis_tuser);
        fail_cnt++;
      end
      if (m_axis_tdata !== ev.data) begin
        $error("event_byte: expected %02h, got %02h", ev.data, m_axis_tdata);
        fail_cnt++;
      end
      if (m_axis_tlast !== ev.last) begin
        $error("last_of_run: expected %0b, got %0b", ev.last, m_axis_tlast);
        fail_cnt++;
      end
    end
  endtask

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) check_event();
      if (sink_hold > 0) begin
        sink_hold--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= sink_calm || ($urandom_range(0, 99) >= 11);
      end
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("adif_field_tokenizer_unit test failed");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = 0;
    if (!src_calm && $urandom_range(0, 99) < 11) gap = 1;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    tokenize_byte(b);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(8'(s[i]));
  endtask

  task automatic send_bytes(input logic [7:0] q[$]);
    foreach (q[i]) send_byte(q[i]);
  endtask

  // hold the input and let every pending event drain
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_limit(input logic [LEN_W-1:0] v);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    len_limit = v;
    cfg_we_i  <= 1'b0;
  endtask

  task automatic test_header_skip();
    send_text("junk<PROGRAMID:4>test<EOR><eoh>");
    send_text("<EOH>");
  endtask

  task automatic test_field_basics();
    send_text("<C:1>");
    send_byte(8'h00);
    send_text("<D:2>");
    send_byte(8'hFF);
    send_byte(CH_GT);
    send_text("<N><eor><EOR>");
    send_text("<EOR:1>z<EOH:2>ab");
  endtask

  task automatic test_long_names();
    send_byte(CH_LT);
    for (int i = 0; i < 34; i++) send_byte(8'h41 + 8'(i % 26));
    send_byte(CH_GT);
    send_byte(CH_LT);
    for (int i = 0; i < 34; i++) send_byte(8'h61 + 8'(i % 26));
    send_text(":1>Z");
  endtask

  task automatic test_bad_lengths();
    send_text("<A:-3>xyz<B: 3>xyz<C:3x>abc<D:99999>q<E:a:2>xy");
    send_text("<F:2:>q<G:0><H:007>abcdefg<I:1:S>");
  endtask

  task automatic test_length_limit();
    set_limit(11'd0);
    send_text("<Z:1>q");
    set_limit(11'd5);
    send_text("<F:5>abcde<F:6>abcdef");
    set_limit(11'd2047);
    send_text("<L:9>abcdefghi<L:2048>");
    set_limit(LIMIT_RESET);
  endtask

  // stall the sink while long names pile up behind it
  task automatic test_backpressure();
    sink_hold = 400;
    repeat (3) begin
      send_byte(CH_LT);
      repeat (30) send_byte(8'h41 + 8'($urandom_range(0, 25)));
      send_text(":2>");
      send_byte(8'($urandom_range(0, 255)));
      send_byte(8'($urandom_range(0, 255)));
    end
    wait_idle();
  endtask

  function automatic logic [7:0] name_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CH_GT || c == CH_COLON);
    return c;
  endfunction

  task automatic send_random_item();
    logic [7:0]  q[$];
    int unsigned pick;
    int unsigned nlen;
    int unsigned vlen;
    string       num;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      nlen = ($urandom_range(0, 15) == 0) ? $urandom_range(28, 40) : $urandom_range(1, 6);
      vlen = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 30) : $urandom_range(0, 6);
      num  = $sformatf("%0d", vlen);
      if ($urandom_range(0, 7) == 0) num = {"0", num};
      q = {q, CH_LT};
      repeat (nlen) q = {q, name_char()};
      q = {q, CH_COLON};
      for (int i = 0; i < num.len(); i++) q = {q, 8'(num[i])};
      if ($urandom_range(0, 7) == 0) q = {q, 8'h53};
      q = {q, CH_GT};
      repeat (vlen) q = {q, 8'($urandom_range(0, 255))};
    end else if (pick < 85) begin
      q = {q, CH_LT};
      q = {q, CH_E};
      q = {q, CH_O};
      q = {q, ((pick < 80) ? CH_R : CH_H)};
      if ($urandom_range(0, 3) == 0) begin
        q = {q, CH_COLON};
        q = {q, CH_0 + 8'd1};
        q = {q, CH_GT};
        q = {q, 8'($urandom_range(0, 255))};
      end else begin
        q = {q, CH_GT};
      end
    end else if (pick < 92) begin
      repeat ($urandom_range(1, 6)) q = {q, 8'($urandom_range(0, 255))};
    end else begin
      q = {q, CH_LT};
      q = {q, 8'h41};
      q = {q, CH_COLON};
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(0, 3))
          0: q = {q, 8'h2D};
          1: q = {q, 8'h20};
          2: q = {q, CH_COLON};
          default: q = {q, CH_0 + 8'($urandom_range(0, 9))};
        endcase
      end
      q = {q, CH_GT};
    end
    send_bytes(q);
  endtask

  task automatic test_random_stream(input int unsigned n_items, input bit calm);
    int unsigned start;
    src_calm  = calm;
    sink_calm = calm;
    start     = active_bytes;
    while (active_bytes - start < n_items) begin
      send_random_item();
      if (!calm && $urandom_range(0, 39) == 0) wait_idle();
    end
    src_calm  = 1'b0;
    sink_calm = 1'b0;
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_header_skip();
    test_field_basics();
    test_long_names();
    test_bad_lengths();
    test_length_limit();
    test_backpressure();
    test_random_stream(25, 1'b1);
    test_random_stream(45, 1'b0);
    set_limit(11'd3);
    test_random_stream(35, 1'b0);

    s_axis_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("adif_field_tokenizer_unit test passed");
    end else begin
      $display("adif_field_tokenizer_unit test failed");
    end
    $finish;
  end

endmodule
